// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

`define BTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`else

`define BTP_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define BTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/btp_pkg.sv -----
// ----------------------------------------------------------------------------
// btp_pkg
// Types, constants and the perturbation table of the bounded table PRNG.
// ----------------------------------------------------------------------------
package btp_pkg;

	localparam int unsigned DATA_W          = 16;
	localparam int unsigned MAX_ROUNDS      = 32;
	localparam int unsigned ROUND_W         = $clog2(MAX_ROUNDS);
	localparam int unsigned EARLY_STOP_FROM = 5;
	localparam logic [DATA_W-1:0] SEED_RESET = 16'hCBFA;

	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_HALVE
	} state_t;

	// Result of one seed round.
	typedef struct packed {
		word_t seed;
		logic  below;
	} step_t;

	function automatic word_t perturb(input logic [3:0] nib);
		word_t w;
		case (nib)
			4'h0:    w = 16'h0008;
			4'h1:    w = 16'h000b;
			4'h2:    w = 16'h0003;
			4'h3:    w = 16'h0006;
			4'h4:    w = 16'h0010;
			4'h5:    w = 16'h000d;
			4'h6:    w = 16'h0002;
			4'h7:    w = 16'h000a;
			4'h8:    w = 16'h0004;
			4'h9:    w = 16'h000f;
			4'ha:    w = 16'h000e;
			4'hb:    w = 16'h0005;
			4'hc:    w = 16'h000c;
			4'hd:    w = 16'h0009;
			4'he:    w = 16'h0007;
			4'hf:    w = 16'h0011;
			default: w = 16'h0000;
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/btp_req_if.sv -----
// ----------------------------------------------------------------------------
// btp_req_if
// Request channel: valid/ready plus the inclusive upper bound.
// ----------------------------------------------------------------------------
interface btp_req_if;
	logic                valid;
	logic                ready;
	btp_pkg::word_t      range_limit;

	modport source (output valid, output range_limit, input ready);
	modport sink   (input valid, input range_limit, output ready);
endinterface

// ----- hw/rtl/btp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// btp_rsp_if
// Response channel: valid/ready plus the bounded random value.
// ----------------------------------------------------------------------------
interface btp_rsp_if;
	logic                valid;
	logic                ready;
	btp_pkg::word_t      random_value;

	modport source (output valid, output random_value, input ready);
	modport sink   (input valid, input random_value, output ready);
endinterface

// ----- hw/rtl/bounded_table_prng_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_table_prng_unit
// Table-perturbed shift-register PRNG returning a value at most the bound.
// ----------------------------------------------------------------------------
// Sequence: 6 to 32 seed rounds, one per cycle through the shared round unit,
//   then the halving state, which shifts the value right until it is at most
//   the bound and loads the response once the output register is free.
// Requests: one at a time; ready returns only in idle, so a new request waits
//   until the previous one is through, longer while the previous response still waits.
// Reset: arst_n clears the sequencer and response valid, and loads the seed with 0xCBFA.
module bounded_table_prng_unit (
	input  logic        clk,
	input  logic        arst_n,
	btp_req_if.sink     req,
	btp_rsp_if.source   rsp
);

	btp_pkg::state_t                  state_q, state_d;
	btp_pkg::word_t                   seed_q;
	btp_pkg::word_t                   limit_q;
	btp_pkg::word_t                   r_q;
	logic [btp_pkg::ROUND_W-1:0]      round_q;
	btp_pkg::word_t                   out_q;
	logic                             out_valid_q;

	btp_pkg::step_t                   step;
	logic                             round_last;
	logic                             early_ok;
	logic                             round_end;
	logic                             above;
	logic                             out_free;
	logic                             req_xfer;
	logic                             out_load;

	// Shared round unit: always fed from the running seed.
	btp_seed_step u_step (
		.seed  (seed_q),
		.limit (limit_q),
		.step  (step)
	);

	assign req_xfer   = req.valid && req.ready;
	assign round_last = round_q == btp_pkg::ROUND_W'(btp_pkg::MAX_ROUNDS - 1);
	assign early_ok   = round_q >= btp_pkg::ROUND_W'(btp_pkg::EARLY_STOP_FROM);
	// Leave the round loop on the last round, or on an early stop below the bound.
	assign round_end  = round_last || (early_ok && step.below);
	assign above      = r_q > limit_q;
	// The output register is free once empty or its transfer completes now.
	assign out_free   = !out_valid_q || rsp.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			btp_pkg::ST_IDLE: begin
				if (req_xfer) state_d = btp_pkg::ST_ROUND;
			end
			btp_pkg::ST_ROUND: begin
				if (round_end) state_d = btp_pkg::ST_HALVE;
			end
			btp_pkg::ST_HALVE: begin
				if (!above && out_free) state_d = btp_pkg::ST_IDLE;
			end
			default: state_d = btp_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			btp_pkg::ST_IDLE:  req.ready = 1'b1;
			btp_pkg::ST_ROUND: out_load  = 1'b0;
			btp_pkg::ST_HALVE: out_load  = !above && out_free;
			default:           req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btp_pkg::ST_IDLE;
			seed_q      <= btp_pkg::SEED_RESET;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Advance the seed once per round; it is kept for the next request.
			if (state_q == btp_pkg::ST_ROUND) begin
				seed_q  <= step.seed;
				round_q <= round_q + 1'b1;
			end
			if (req_xfer) begin
				round_q <= '0;
			end
			// Hold the response until its transfer, then drop valid.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			limit_q <= req.range_limit;
		end
		if (state_q == btp_pkg::ST_ROUND && round_end) begin
			r_q <= step.seed;
		end else if (state_q == btp_pkg::ST_HALVE && above) begin
			r_q <= r_q >> 1;
		end
		if (out_load) begin
			out_q <= r_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.random_value = out_q;

	`include "assert_macros.svh"

	// A request always starts the round loop from round zero.
	`BTP_ASSERT_NEXT(a_start_round, clk, arst_n, req_xfer,
		state_q == btp_pkg::ST_ROUND && round_q == '0)
	// The round loop never runs past its last round.
	`BTP_ASSERT_NEXT(a_round_bound, clk, arst_n,
		state_q == btp_pkg::ST_ROUND && round_last, state_q == btp_pkg::ST_HALVE)
	// Finishing the halving always presents a response.
	`BTP_ASSERT_NEXT(a_result_shown, clk, arst_n, out_load, rsp.valid)
	// No request is taken while an item is in flight.
	`BTP_ASSERT_IMP(a_busy_no_ready, clk, arst_n,
		state_q != btp_pkg::ST_IDLE, !req.ready)

endmodule

// ----- hw/rtl/btp_seed_step.sv -----
// ----------------------------------------------------------------------------
// btp_seed_step
// One seed round: shift with feedback, table add, compare against the bound.
// ----------------------------------------------------------------------------
module btp_seed_step (
	input  btp_pkg::word_t seed,
	input  btp_pkg::word_t limit,
	output btp_pkg::step_t step
);

	btp_pkg::word_t shifted;

	// Drop bit 15, bring in bit2 ^ bit3 of the old seed.
	assign shifted = {seed[btp_pkg::DATA_W-2:0], seed[2] ^ seed[3]};

	always_comb begin
		step.seed  = shifted + btp_pkg::perturb(shifted[3:0]);
		step.below = step.seed < limit;
	end

endmodule

// ----- bench/bounded_table_prng_unit_test.sv -----
// ----------------------------------------------------------------------------
// bounded_table_prng_unit_test
// Self-checking bench for the bounded table PRNG: a table of directed bounds,
// then random bounds of several classes, each transfer checked against an
// in-bench model of the seed rounds and the halving.
// ----------------------------------------------------------------------------
module bounded_table_prng_unit_test;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_BOUNDS  = 1400;
	localparam int MAX_IDLE       = 13;
	// Worst quiet spell: sender gap, the block's rounds and halving, receiver stall.
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 60;

	// Offsets added after each shift, one byte per low-nibble value, entry 0 lowest.
	localparam logic [127:0] NIBBLE_OFFSETS = {
		8'h11, 8'h07, 8'h09, 8'h0c, 8'h05, 8'h0e, 8'h0f, 8'h04,
		8'h0a, 8'h02, 8'h0d, 8'h10, 8'h06, 8'h03, 8'h0b, 8'h08
	};

	// One directed row: the bound, and a typed-in value where it is obvious.
	typedef struct packed {
		logic           pinned;
		btp_pkg::word_t bound;
		btp_pkg::word_t value;
	} bound_row_t;

	localparam int DIRECTED_ROWS = 16;

	bound_row_t directed_rows [DIRECTED_ROWS] = '{
		'{1'b0, 16'hFFFF, 16'h0000},  // first draw after reset, full bound
		'{1'b1, 16'h0000, 16'h0000},  // zero bound: all rounds, halve to zero
		'{1'b1, 16'h0000, 16'h0000},  // zero bound again from the new seed
		'{1'b0, 16'h0001, 16'h0000},  // near-zero bound, long halving
		'{1'b0, 16'h0002, 16'h0000},
		'{1'b0, 16'h0003, 16'h0000},
		'{1'b0, 16'hFFFE, 16'h0000},
		'{1'b0, 16'h8000, 16'h0000},
		'{1'b0, 16'h7FFF, 16'h0000},
		'{1'b0, 16'h00FF, 16'h0000},
		'{1'b0, 16'h0100, 16'h0000},
		'{1'b0, 16'hAAAA, 16'h0000},
		'{1'b0, 16'h5555, 16'h0000},
		'{1'b0, 16'hFFFF, 16'h0000},  // full bound, no halving
		'{1'b0, 16'h0001, 16'h0000},
		'{1'b1, 16'h0000, 16'h0000}
	};

	logic clk;
	logic arst_n;

	btp_req_if req_ch ();
	btp_rsp_if rsp_ch ();

	bounded_table_prng_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model state and the queue of values still owed by the block.
	btp_pkg::word_t seed_model;
	btp_pkg::word_t value_q [$];

	// Typed-in value that travels with the bound currently offered.
	logic           pin_flag;
	btp_pkg::word_t pin_value;

	// Set to run both sides with no idle cycles for a stretch.
	logic  no_idle;

	int errors;
	int bounds_taken;
	int values_checked;
	int zero_bounds;
	int full_bounds;
	int quiet_cycles;

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// One round: shift left, feed bit2 ^ bit3 in, add the offset of the new nibble.
	function automatic btp_pkg::word_t seed_round(input btp_pkg::word_t s);
		btp_pkg::word_t n;
		n = {s[btp_pkg::DATA_W-2:0], s[2] ^ s[3]};
		return n + btp_pkg::word_t'(NIBBLE_OFFSETS[n[3:0]*8 +: 8]);
	endfunction

	// Advance the seed model for one request and return the bounded value.
	function automatic btp_pkg::word_t draw_bounded(input btp_pkg::word_t bound);
		btp_pkg::word_t s;
		btp_pkg::word_t r;
		s = seed_model;
		for (int k = 0; k < btp_pkg::MAX_ROUNDS; k++) begin
			s = seed_round(s);
			// stop early only from the sixth round on
			if (k >= btp_pkg::EARLY_STOP_FROM && s < bound)
				break;
		end
		seed_model = s;
		r = s;
		while (r > bound)
			r = r >> 1;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input btp_pkg::word_t got,
		input btp_pkg::word_t want);
		$display("mismatch at %0t: %s got 0x%04h want 0x%04h", $realtime, what, got, want);
		errors++;
	endtask

	// Offer one bound: idle for a drawn gap, then hold valid until the transfer.
	task automatic offer_bound(input btp_pkg::word_t bound, input logic pinned,
		input btp_pkg::word_t value);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid       <= 1'b0;
			req_ch.range_limit <= btp_pkg::word_t'($urandom);
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.range_limit <= bound;
		pin_flag           <= pinned;
		pin_value          <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Pick a bound class so that small, large and extreme bounds all recur.
	function automatic btp_pkg::word_t random_bound();
		btp_pkg::word_t b;
		case ($urandom_range(0, 9))
			0:       b = '0;
			1:       b = '1;
			2:       b = btp_pkg::word_t'($urandom_range(1, 15));
			3:       b = btp_pkg::word_t'($urandom_range(16, 255));
			4:       b = btp_pkg::word_t'($urandom_range(16'hF000, 16'hFFFE));
			5:       b = btp_pkg::word_t'((32'h1 << $urandom_range(0, 15))
				- $urandom_range(0, 1));
			default: b = btp_pkg::word_t'($urandom);
		endcase
		return b;
	endfunction

	// Receiver: draw a stall per value; when stalling, hold ready low until
	// valid shows up, then wait it out so the stall lands on a live response.
	initial begin
		int stall;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
			@(negedge clk);
			if (stall == 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b0;
				@(posedge clk);
				while (!rsp_ch.valid)
					@(posedge clk);
				repeat (stall - 1) @(posedge clk);
				@(negedge clk);
				rsp_ch.ready <= 1'b1;
			end
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
		end
	end

	// Monitor: sample both channels at the rising edge. Retire the oldest
	// expectation before queuing a new one, since a response can never belong
	// to a request taken at the same edge.
	always @(posedge clk) begin
		btp_pkg::word_t predicted;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				values_checked++;
				if (value_q.size() == 0)
					report_mismatch("response with nothing pending", rsp_ch.random_value, '0);
				else if (rsp_ch.random_value !== value_q[0]) begin
					report_mismatch("random_value", rsp_ch.random_value, value_q[0]);
					void'(value_q.pop_front());
				end else
					void'(value_q.pop_front());
			end
			if (req_ch.valid && req_ch.ready) begin
				bounds_taken++;
				if (req_ch.range_limit == '0)
					zero_bounds++;
				if (req_ch.range_limit == '1)
					full_bounds++;
				// keep the model in step even when the value is typed in
				predicted = draw_bounded(req_ch.range_limit);
				value_q.push_back(pin_flag ? pin_value : predicted);
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d values pending",
					quiet_cycles, value_q.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		errors         = 0;
		bounds_taken   = 0;
		values_checked = 0;
		zero_bounds    = 0;
		full_bounds    = 0;
		quiet_cycles   = 0;
		no_idle        = 1'b0;
		seed_model     = btp_pkg::SEED_RESET;
		pin_flag       = 1'b0;
		pin_value      = '0;

		// Drive every input to a known value before reset lets go.
		req_ch.valid       = 1'b0;
		req_ch.range_limit = '0;
		rsp_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table.
		foreach (directed_rows[i])
			offer_bound(directed_rows[i].bound, directed_rows[i].pinned,
				directed_rows[i].value);

		// Random bounds; flip into a no-idle stretch now and then.
		for (int n = 0; n < RANDOM_BOUNDS; n++) begin
			if (n % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			offer_bound(random_bound(), 1'b0, '0);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		no_idle      = 1'b0;

		// Drain: wait for every owed value, then let the block settle.
		while (value_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d bound requests, %0d of them zero and %0d full-scale",
			bounds_taken, zero_bounds, full_bounds);
		$display("compared %0d random values, %0d mismatches", values_checked, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
